// ----- sv/hkrd_pkg.sv -----
// hkrd_pkg: shared types, constants and helpers for the keyboard report differ
// used by hkrd_ctrl, hkrd_dp and hid_key_report_differ_top
`timescale 1ns / 1ps
`default_nettype none

package hkrd_pkg;

	localparam int unsigned SLOT_W    = 8;
	localparam int unsigned IN_FIELDS = 6;
	localparam int unsigned IN_W      = SLOT_W * IN_FIELDS;
	localparam int unsigned OUT_W     = 16;
	localparam int unsigned USER_W    = 2;
	localparam int unsigned LOCK_W    = 3;

	localparam logic [SLOT_W-1:0] ROLLOVER_CODE = 8'h01;
	localparam logic [SLOT_W-1:0] USAGE_NUM     = 8'h53;
	localparam logic [SLOT_W-1:0] USAGE_CAPS    = 8'h39;
	localparam logic [SLOT_W-1:0] USAGE_SCROLL  = 8'h47;

	localparam logic [LOCK_W-1:0] LOCK_NONE       = 3'b000;
	localparam logic [LOCK_W-1:0] LOCK_NUM_BIT    = 3'b001;
	localparam logic [LOCK_W-1:0] LOCK_CAPS_BIT   = 3'b010;
	localparam logic [LOCK_W-1:0] LOCK_SCROLL_BIT = 3'b100;

	localparam logic KIND_RELEASE = 1'b0;
	localparam logic KIND_PRESS   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_STORE
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic scan;
		logic emit;
		logic store;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic rollover;
		logic scan_last;
		logic emit_last;
		logic step_ok;
	} sts_t;

	function automatic logic [LOCK_W-1:0] lock_mask(input logic [SLOT_W-1:0] code);
		logic [LOCK_W-1:0] m;
		m = LOCK_NONE;
		case (code)
			USAGE_NUM:    m = LOCK_NUM_BIT;
			USAGE_CAPS:   m = LOCK_CAPS_BIT;
			USAGE_SCROLL: m = LOCK_SCROLL_BIT;
			default:      m = LOCK_NONE;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- sv/hkrd_ctrl.sv -----
// hkrd_ctrl: sequencing state machine of the keyboard report differ
// depends on hkrd_pkg (state_t, cmd_t, sts_t)
`timescale 1ns / 1ps
`default_nettype none

module hkrd_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            s_tvalid,
	output logic           s_tready,
	input  hkrd_pkg::sts_t sts,
	output hkrd_pkg::cmd_t cmd
);

	hkrd_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hkrd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			hkrd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nxt   = hkrd_pkg::ST_SCAN;
				end
			end
			hkrd_pkg::ST_SCAN: begin
				// a rollover report leaves the stored report and the lock state untouched
				if (sts.rollover) begin
					state_nxt = hkrd_pkg::ST_IDLE;
				end else begin
					cmd.scan = 1'b1;
					if (sts.scan_last) begin
						state_nxt = hkrd_pkg::ST_EMIT;
					end
				end
			end
			hkrd_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.step_ok && sts.emit_last) begin
					state_nxt = hkrd_pkg::ST_STORE;
				end
			end
			hkrd_pkg::ST_STORE: begin
				cmd.store = 1'b1;
				state_nxt = hkrd_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = hkrd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/hkrd_dp.sv -----
// hkrd_dp: report registers, slot compare, event walk, lock state and output register
// depends on hkrd_pkg (cmd_t, sts_t, constants, lock_mask)
`timescale 1ns / 1ps
`default_nettype none

module hkrd_dp #(
	parameter int unsigned USED_SLOTS = 6
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [hkrd_pkg::IN_W-1:0]    s_tdata,
	input  hkrd_pkg::cmd_t               cmd,
	output hkrd_pkg::sts_t               sts,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [hkrd_pkg::OUT_W-1:0]   m_tdata,
	output logic [hkrd_pkg::USER_W-1:0]  m_tuser,
	output logic                         m_tlast
);

	localparam int unsigned KW = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
	localparam int unsigned EV = 2 * USED_SLOTS;
	localparam int unsigned PW = $clog2(EV);
	localparam int unsigned SW = hkrd_pkg::SLOT_W;
	localparam int unsigned LW = hkrd_pkg::LOCK_W;

	logic [SW-1:0] now_q  [USED_SLOTS];
	logic [SW-1:0] prev_q [USED_SLOTS];
	logic          rollover_q;
	logic [KW-1:0] k_q;
	logic [PW-1:0] p_q;
	logic [EV-1:0] ev_q;
	logic [LW-1:0] lock_on_q, lock_held_q;

	logic          out_valid_q;
	logic          out_kind_q, out_lock_q, out_led_q, out_last_q;
	logic [SW-1:0] out_usage_q;
	logic [LW-1:0] out_bits_q;

	logic          in_rollover;
	logic          rel_miss, prs_miss;
	logic          out_free, load;
	logic [PW-1:0] p_new;
	logic          cur_kind;
	logic [SW-1:0] cur_code;
	logic [LW-1:0] cur_mask;
	logic [LW-1:0] on_nxt, held_nxt;
	logic          led_nxt, last_nxt;

	// rollover report: every used slot holds the error code
	always_comb begin
		in_rollover = 1'b1;
		for (int i = 0; i < USED_SLOTS; i++) begin
			if (s_tdata[i*SW +: SW] != hkrd_pkg::ROLLOVER_CODE) begin
				in_rollover = 1'b0;
			end
		end
	end

	// slot k against the whole other report
	always_comb begin
		rel_miss = 1'b1;
		prs_miss = 1'b1;
		for (int j = 0; j < USED_SLOTS; j++) begin
			if (now_q[j] == prev_q[k_q]) begin
				rel_miss = 1'b0;
			end
			if (prev_q[j] == now_q[k_q]) begin
				prs_miss = 1'b0;
			end
		end
	end

	// releases walk the old slots first, then presses walk the new slots
	always_comb begin
		p_new    = p_q - PW'(USED_SLOTS);
		cur_kind = (p_q >= PW'(USED_SLOTS)) ? hkrd_pkg::KIND_PRESS : hkrd_pkg::KIND_RELEASE;
		cur_code = (cur_kind == hkrd_pkg::KIND_PRESS) ? now_q[p_new[KW-1:0]]
							      : prev_q[p_q[KW-1:0]];
		cur_mask = hkrd_pkg::lock_mask(cur_code);
		on_nxt   = lock_on_q;
		held_nxt = lock_held_q;
		if (cur_kind == hkrd_pkg::KIND_PRESS) begin
			on_nxt   = lock_on_q ^ (cur_mask & ~lock_held_q);
			held_nxt = lock_held_q | cur_mask;
		end else begin
			held_nxt = lock_held_q & ~cur_mask;
		end
		led_nxt  = (cur_kind == hkrd_pkg::KIND_PRESS) && (held_nxt != lock_held_q);
		last_nxt = ((ev_q >> p_q) >> 1) == '0;
	end

	assign out_free = !out_valid_q || m_tready;
	assign load     = cmd.emit && ev_q[p_q] && out_free;

	assign sts.rollover  = rollover_q;
	assign sts.scan_last = (k_q == KW'(USED_SLOTS - 1));
	assign sts.emit_last = (p_q == PW'(EV - 1));
	assign sts.step_ok   = !ev_q[p_q] || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rollover_q  <= 1'b0;
			k_q         <= '0;
			p_q         <= '0;
			lock_on_q   <= hkrd_pkg::LOCK_NUM_BIT;
			lock_held_q <= hkrd_pkg::LOCK_NONE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < USED_SLOTS; i++) begin
				prev_q[i] <= '0;
			end
		end else begin
			if (cmd.capture) begin
				rollover_q <= in_rollover;
				k_q        <= '0;
				p_q        <= '0;
			end
			if (cmd.scan) begin
				k_q <= k_q + KW'(1);
			end
			if (cmd.emit && sts.step_ok && !sts.emit_last) begin
				p_q <= p_q + PW'(1);
			end
			if (load) begin
				lock_on_q   <= on_nxt;
				lock_held_q <= held_nxt;
			end
			if (cmd.store) begin
				for (int i = 0; i < USED_SLOTS; i++) begin
					prev_q[i] <= now_q[i];
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < USED_SLOTS; i++) begin
				now_q[i] <= s_tdata[i*SW +: SW];
			end
		end
		if (cmd.scan) begin
			ev_q[PW'(k_q)]                   <= rel_miss;
			ev_q[PW'(k_q) + PW'(USED_SLOTS)] <= prs_miss;
		end
		if (load) begin
			out_kind_q  <= cur_kind;
			out_usage_q <= cur_code;
			out_lock_q  <= (cur_mask != hkrd_pkg::LOCK_NONE);
			out_bits_q  <= on_nxt;
			out_led_q   <= led_nxt;
			out_last_q  <= last_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_led_q, out_bits_q, out_usage_q};
	assign m_tuser  = {out_lock_q, out_kind_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_led_on_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_led_q |-> out_kind_q == hkrd_pkg::KIND_PRESS && out_lock_q)
		else $error("led update on a release or non-lock event");
	a_no_rollover_event: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !rollover_q)
		else $error("event emitted for a rollover report");
	a_walk_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.emit && !cmd.capture |=> $stable(p_q))
		else $error("event pointer moved outside the emit phase");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.scan, cmd.emit, cmd.store}))
		else $error("overlapping datapath commands");
`endif

endmodule

`default_nettype wire

// ----- sv/hid_key_report_differ_top.sv -----
// hid_key_report_differ_top: keyboard report in, key press/release events out
// depends on hkrd_pkg, hkrd_ctrl, hkrd_dp
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata: slot_0 .. slot_5, 8 bits each
// m_*      out  m_tvalid/m_tready  m_tdata, m_tuser, m_tlast (one key event)
//
// with n = min(KEY_SLOTS, 6) used slots a report passes an accept step, n compare
// steps (one slot a cycle against the whole other report), a walk over 2*n event
// positions and a store step; a rollover report goes back to idle after its accept step
// events leave one at a time through the output register; m_tready low holds
// the event walk at a pending event while that register is full
// reset: stored report all zeros, num lock on, nothing held
`timescale 1ns / 1ps
`default_nettype none

module hid_key_report_differ_top #(
	parameter int unsigned KEY_SLOTS = 6
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [hkrd_pkg::IN_W-1:0]        s_tdata,  // slot_0 .. slot_5, 8 bits each
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [hkrd_pkg::OUT_W-1:0]       m_tdata,  // usage[7:0], lock_bits[10:8], led_update[11]
	output logic [hkrd_pkg::USER_W-1:0]      m_tuser,  // event_kind[0], is_lock[1]
	output logic                             m_tlast
);

	localparam int unsigned USED_SLOTS =
		(KEY_SLOTS < hkrd_pkg::IN_FIELDS) ? KEY_SLOTS : hkrd_pkg::IN_FIELDS;

	hkrd_pkg::cmd_t cmd;
	hkrd_pkg::sts_t sts;

	hkrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hkrd_dp #(
		.USED_SLOTS (USED_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for hid_key_report_differ_top, reports in, key events out
// depends on hkrd_pkg and the differ rtl; an in-bench predictor checks every event
module tb_top;
	import hkrd_pkg::*;

	localparam int unsigned KEY_SLOTS   = 6;
	localparam int unsigned RAND_ITEMS  = 300;
	localparam int unsigned TAIL_CYCLES = 3 * KEY_SLOTS + 20;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned MAX_SHOWN   = 10;

	typedef struct packed {
		logic                             drain;  // hold until all events are back
		logic                             quiet;  // no idle cycles on either side
		logic [IN_FIELDS-1:0][SLOT_W-1:0] slot;
	} report_t;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] usage;
		logic              is_lock;
		logic [LOCK_W-1:0] lock_bits;
		logic              led;
		logic              last;
	} key_event_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic [USER_W-1:0]   m_tuser;
	logic                m_tlast;

	// predictor state
	logic [IN_FIELDS-1:0][SLOT_W-1:0] stored_keys;
	logic [LOCK_W-1:0]                locks_on;
	logic [LOCK_W-1:0]                locks_held;

	report_t     reports_to_send[$];
	key_event_t  pending_events[$];
	report_t     cur_report;
	logic        quiet_phase = 1'b0;
	int unsigned gap_left    = 0;
	int unsigned stall_left  = 0;
	int unsigned errors      = 0;
	int unsigned cycles      = 0;

	hid_key_report_differ_top #(.KEY_SLOTS(KEY_SLOTS)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected key events for one accepted report, updates the lock state
	task automatic predict_events(input logic [IN_FIELDS-1:0][SLOT_W-1:0] rpt);
		key_event_t        evs[2*IN_FIELDS];
		key_event_t        ev;
		int                n;
		logic              rollover;
		logic              found;
		logic [SLOT_W-1:0] code;
		logic [SLOT_W-1:0] other;
		logic [LOCK_W-1:0] mask;
		logic [LOCK_W-1:0] held_was;
		n = 0;
		rollover = 1'b1;
		for (int k = 0; k < KEY_SLOTS; k++)
			if (rpt[k] != ROLLOVER_CODE)
				rollover = 1'b0;
		if (rollover)
			return;
		// pass 0: old codes gone from the new report, pass 1: new codes absent before
		for (int pass = 0; pass < 2; pass++) begin
			for (int k = 0; k < KEY_SLOTS; k++) begin
				code = (pass == 0) ? stored_keys[k] : rpt[k];
				found = 1'b0;
				for (int j = 0; j < KEY_SLOTS; j++) begin
					other = (pass == 0) ? rpt[j] : stored_keys[j];
					if (other == code)
						found = 1'b1;
				end
				if (!found) begin
					case (code)
						USAGE_NUM:    mask = LOCK_NUM_BIT;
						USAGE_CAPS:   mask = LOCK_CAPS_BIT;
						USAGE_SCROLL: mask = LOCK_SCROLL_BIT;
						default:      mask = LOCK_NONE;
					endcase
					ev = '0;
					ev.usage = code;
					ev.is_lock = (mask != LOCK_NONE);
					if (pass == 1) begin
						ev.kind = KIND_PRESS;
						held_was = locks_held;
						// a lock already held does not toggle again
						locks_on = locks_on ^ (mask & ~locks_held);
						locks_held = locks_held | mask;
						ev.led = (locks_held != held_was);
					end else begin
						ev.kind = KIND_RELEASE;
						locks_held = locks_held & ~mask;
					end
					ev.lock_bits = locks_on;
					evs[n] = ev;
					n++;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			ev = evs[i];
			ev.last = (i == n - 1);
			pending_events.push_back(ev);
		end
		stored_keys = rpt;
	endtask

	task automatic queue_report(input logic [SLOT_W-1:0] s0, s1, s2, s3, s4, s5);
		report_t r;
		r = '0;
		r.slot = {s5, s4, s3, s2, s1, s0};
		reports_to_send.push_back(r);
	endtask

	// biased toward lock keys, empty slots and the rollover code
	function automatic logic [SLOT_W-1:0] pick_code();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return USAGE_NUM;
		else if (sel < 20)
			return USAGE_CAPS;
		else if (sel < 30)
			return USAGE_SCROLL;
		else if (sel < 40)
			return 8'h00;
		else if (sel < 48)
			return ROLLOVER_CODE;
		else if (sel < 53)
			return 8'hFF;
		else if (sel < 75)
			return 8'h04 + 8'($urandom_range(0, 7));
		else
			return 8'($urandom_range(0, 255));
	endfunction

	always @(posedge clk or negedge arst_n) begin : report_driver
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			gap_left <= 0;
			quiet_phase <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				predict_events(cur_report.slot);
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (reports_to_send.size() == 0 ||
					(reports_to_send[0].drain && pending_events.size() != 0)) begin
				s_tvalid <= 1'b0;
			end else begin
				cur_report = reports_to_send.pop_front();
				s_tdata <= cur_report.slot;
				s_tvalid <= 1'b1;
				quiet_phase <= cur_report.quiet;
				gap_left <= cur_report.quiet ? 0 : $urandom_range(0, 5);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : event_monitor
		key_event_t  got;
		key_event_t  want;
		int unsigned stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (m_tvalid && m_tready) begin
			got.kind = m_tuser[0];
			got.usage = m_tdata[7:0];
			got.is_lock = m_tuser[1];
			got.lock_bits = m_tdata[10:8];
			got.led = m_tdata[11];
			got.last = m_tlast;
			if (pending_events.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("unexpected event: kind=%0d usage=%02h lock=%0d bits=%03b led=%0d last=%0d",
						got.kind, got.usage, got.is_lock, got.lock_bits, got.led, got.last);
			end else begin
				want = pending_events.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("event mismatch: kind/usage/lock/bits/led/last exp %0d %02h %0d %03b %0d %0d got %0d %02h %0d %03b %0d %0d",
							want.kind, want.usage, want.is_lock, want.lock_bits, want.led,
							want.last, got.kind, got.usage, got.is_lock, got.lock_bits,
							got.led, got.last);
				end
			end
			stall = quiet_phase ? 0 : $urandom_range(0, 5);
			stall_left <= stall;
			m_tready <= (stall == 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= (stall_left == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		report_t                          r;
		logic [IN_FIELDS-1:0][SLOT_W-1:0] shadow;
		logic [63:0]                      rnd;
		int unsigned                      sel;
		int unsigned                      pos;
		stored_keys = '0;
		locks_on = LOCK_NUM_BIT;
		locks_held = LOCK_NONE;

		// directed reports
		queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // same as reset, no events
		queue_report(8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);  // rollover, ignored
		queue_report(USAGE_NUM, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		queue_report(USAGE_NUM, USAGE_NUM, USAGE_CAPS, USAGE_SCROLL, 8'h00, 8'h00);
		queue_report(USAGE_NUM, USAGE_CAPS, USAGE_SCROLL, 8'h00, 8'h00, 8'h00);
		queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // all locks released
		queue_report(USAGE_NUM, USAGE_NUM, 8'h00, 8'h00, 8'h00, 8'h00);  // second press held
		queue_report(8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h04);  // almost rollover
		queue_report(8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);
		queue_report(8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15);  // twelve events
		queue_report(8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25);
		queue_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_report(8'h80, 8'h7F, 8'hAA, 8'h55, 8'hFE, 8'h00);  // code zero pressed
		queue_report(USAGE_CAPS, USAGE_CAPS, USAGE_SCROLL, USAGE_SCROLL, USAGE_NUM, USAGE_NUM);
		queue_report(USAGE_CAPS, USAGE_SCROLL, 8'h00, 8'hFF, 8'h01, 8'h02);  // duplicate releases
		queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

		// random reports, mostly small edits of the previous one
		shadow = '0;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			r = '0;
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				for (int k = 0; k < IN_FIELDS; k++)
					r.slot[k] = ROLLOVER_CODE;
			end else if (sel < 18) begin
				rnd = {$urandom, $urandom};
				r.slot = rnd[IN_W-1:0];
			end else if (sel < 25) begin
				r.slot = shadow;
			end else if (sel < 35) begin
				for (int k = 0; k < IN_FIELDS; k++)
					r.slot[k] = pick_code();
			end else begin
				r.slot = shadow;
				for (int c = $urandom_range(1, 3); c > 0; c--) begin
					pos = $urandom_range(0, IN_FIELDS - 1);
					r.slot[pos] = pick_code();
				end
			end
			r.drain = (i % 40 == 0);
			r.quiet = (i >= 140 && i < 190);
			shadow = r.slot;
			reports_to_send.push_back(r);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (reports_to_send.size() != 0 || s_tvalid)
			@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
